// ===== rtl/core/rurm_pkg.sv =====
package rurm_pkg;

	localparam logic [15:0] MIN_ECHO_US   = 16'd100;
	localparam logic [15:0] MAX_ECHO_US   = 16'd25000;
	localparam logic [15:0] US_PER_CM     = 16'd58;
	localparam logic [15:0] HYST_MIN_US   = 16'd5800;
	localparam logic [13:0] CLEAR_MARK_Q4 = 14'd15984;
	localparam logic [25:0] MS_PER_S      = 26'd1000;

	// floor(16*w/58) is computed as floor(8*w/29) by a scaled reciprocal.
	localparam int          DIV_SHIFT = 28;
	localparam logic [23:0] RECIP_29  = 24'd9256396;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_POLL_PERIOD = 2'd0,
		REG_TRIGGER     = 2'd1,
		REG_CLEAR       = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] pub_period;
		logic [9:0]  trigger_cm;
		logic [9:0]  clear_dist;
	} cfg_t;

	typedef struct packed {
		logic [15:0] width_a;
		logic [15:0] width_b;
		logic [15:0] width_c;
		logic        echo_ok_a;
		logic        echo_ok_b;
		logic        echo_ok_c;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  valid_pings;
		logic [12:0] distance_q4;
		logic        have_distance;
		logic        is_clear;
		logic        trigger_fired;
		logic [31:0] trigger_total;
		logic        publish;
		logic [13:0] publish_value_q4;
	} res_t;

	typedef struct packed {
		logic        near_flag;
		logic [31:0] last_publish_ms;
		logic [31:0] trigger_counter;
	} st_t;

endpackage

// ===== rtl/core/ultrasonic_range_median_trigger_top.sv =====
// The input register feeds the ping evaluation and state update, and the result
// register, which parts the two channels, loads it when the output is not stalled.
// Throughput: one request per cycle while out_stall is low.
// Reset: arst_n clears the pipeline, the proximity state, the trigger count, the
// last publish time and the registers (poll period 1, trigger and clear 0).
module ultrasonic_range_median_trigger_top import rurm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       width_a,
	input  logic [15:0]       width_b,
	input  logic [15:0]       width_c,
	input  logic              echo_ok_a,
	input  logic              echo_ok_b,
	input  logic              echo_ok_c,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        valid_pings,
	output logic [12:0]       distance_q4,
	output logic              have_distance,
	output logic              is_clear,
	output logic              trigger_fired,
	output logic [31:0]       trigger_total,
	output logic              publish,
	output logic [13:0]       publish_value_q4
);

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	res_t res_d, res_q;
	logic out_valid_q;
	st_t  st_q, st_d;
	logic load_out, adv_s1, take_in;

	rurm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rurm_eval u_eval (
		.req    (req_s1),
		.cfg    (cfg),
		.st     (st_q),
		.res    (res_d),
		.st_nxt (st_d)
	);

	assign load_out = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && load_out;
	assign in_stall = valid_s1 && !load_out;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				st_q <= st_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1.width_a   <= width_a;
			req_s1.width_b   <= width_b;
			req_s1.width_c   <= width_c;
			req_s1.echo_ok_a <= echo_ok_a;
			req_s1.echo_ok_b <= echo_ok_b;
			req_s1.echo_ok_c <= echo_ok_c;
			req_s1.now_ms    <= now_ms;
		end
		if (adv_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign valid_pings      = res_q.valid_pings;
	assign distance_q4      = res_q.distance_q4;
	assign have_distance    = res_q.have_distance;
	assign is_clear         = res_q.is_clear;
	assign trigger_fired    = res_q.trigger_fired;
	assign trigger_total    = res_q.trigger_total;
	assign publish          = res_q.publish;
	assign publish_value_q4 = res_q.publish_value_q4;

`ifndef NO_ASSERTIONS
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.is_clear && res_q.have_distance))
		else $error("clear and distance flags both set");

	a_fire_near: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.trigger_fired |-> res_q.have_distance)
		else $error("trigger fired without a near reading");

	a_pub_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.publish |-> res_q.publish_value_q4 == 14'd0)
		else $error("publish value shown without publish");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_d.trigger_fired |=>
		st_q.trigger_counter == $past(st_q.trigger_counter) + 32'd1)
		else $error("trigger count did not step on a trigger");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("stalled request dropped from the input register");
`endif

endmodule

// ===== rtl/core/rurm_cfg.sv =====
module rurm_cfg import rurm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pub_period <= 16'd1;
			cfg_q.trigger_cm <= 10'd0;
			cfg_q.clear_dist <= 10'd0;
		end else if (wr_en) begin
			unique case (idx)
				REG_POLL_PERIOD: cfg_q.pub_period <= pwdata[15:0];
				REG_TRIGGER:     cfg_q.trigger_cm <= pwdata[9:0];
				REG_CLEAR:       cfg_q.clear_dist <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_POLL_PERIOD: prdata = {16'd0, cfg_q.pub_period};
			REG_TRIGGER:     prdata = {22'd0, cfg_q.trigger_cm};
			REG_CLEAR:       prdata = {22'd0, cfg_q.clear_dist};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/rurm_eval.sv =====
module rurm_eval import rurm_pkg::*; (
	input  req_t req,
	input  cfg_t cfg,
	input  st_t  st,
	output res_t res,
	output st_t  st_nxt
);

	logic        ok_a, ok_b, ok_c;
	logic [15:0] za, zb, zc;
	logic [1:0]  n;
	logic [15:0] lo, hi, med, mx_ab, mx, w;
	logic [18:0] w8;
	logic [42:0] prod;
	logic [12:0] dist_val;
	logic [15:0] clr_thr, near_thr, hyst;
	logic [19:0] rearm_lhs, rearm_rhs;
	logic [15:0] period;
	logic [25:0] limit;
	logic [31:0] elapsed;
	logic        any, clr, rearm, fire, pub;

	assign ok_a = req.echo_ok_a && req.width_a >= MIN_ECHO_US && req.width_a <= MAX_ECHO_US;
	assign ok_b = req.echo_ok_b && req.width_b >= MIN_ECHO_US && req.width_b <= MAX_ECHO_US;
	assign ok_c = req.echo_ok_c && req.width_c >= MIN_ECHO_US && req.width_c <= MAX_ECHO_US;

	assign za = ok_a ? req.width_a : 16'd0;
	assign zb = ok_b ? req.width_b : 16'd0;
	assign zc = ok_c ? req.width_c : 16'd0;
	assign n  = {1'b0, ok_a} + {1'b0, ok_b} + {1'b0, ok_c};
	assign any = (n != 2'd0);

	// With fewer than three valid pings the invalid ones read as zero, so the
	// largest of the three is the lone value or the larger of the pair.
	assign lo    = (req.width_a < req.width_b) ? req.width_a : req.width_b;
	assign hi    = (req.width_a < req.width_b) ? req.width_b : req.width_a;
	assign med   = (req.width_c < lo) ? lo : ((req.width_c > hi) ? hi : req.width_c);
	assign mx_ab = (za > zb) ? za : zb;
	assign mx    = (mx_ab > zc) ? mx_ab : zc;
	assign w     = (n == 2'd3) ? med : mx;

	assign w8       = {w, 3'b000};
	assign prod     = {24'd0, w8} * {19'd0, RECIP_29};
	assign dist_val = prod[DIV_SHIFT +: 13];

	assign clr_thr  = 16'(32'(cfg.clear_dist) * 32'(US_PER_CM));
	assign near_thr = 16'(32'(cfg.trigger_cm) * 32'(US_PER_CM));
	assign hyst     = (near_thr < HYST_MIN_US) ? HYST_MIN_US : near_thr;
	assign rearm_lhs = {4'd0, w} * 20'd10;
	assign rearm_rhs = {4'd0, near_thr} * 20'd10 + {4'd0, hyst};

	assign clr   = (cfg.clear_dist != 10'd0) && (w >= clr_thr);
	assign rearm = clr || (rearm_lhs >= rearm_rhs);
	assign fire  = any && (cfg.trigger_cm != 10'd0) && !rearm && !st.near_flag &&
		(w < near_thr);

	assign period  = (cfg.pub_period == 16'd0) ? 16'd1 : cfg.pub_period;
	assign limit   = {10'd0, period} * MS_PER_S;
	assign elapsed = req.now_ms - st.last_publish_ms;
	assign pub     = any && (elapsed >= {6'd0, limit});

	always_comb begin
		st_nxt = st;
		if (any && cfg.trigger_cm != 10'd0) begin
			if (rearm) begin
				st_nxt.near_flag = 1'b0;
			end else if (fire) begin
				st_nxt.near_flag = 1'b1;
			end
		end
		if (fire) begin
			st_nxt.trigger_counter = st.trigger_counter + 32'd1;
		end
		if (pub) begin
			st_nxt.last_publish_ms = req.now_ms;
		end
	end

	always_comb begin
		res.valid_pings      = n;
		res.distance_q4      = any ? dist_val : 13'd0;
		res.have_distance    = any && !clr;
		res.is_clear         = any && clr;
		res.trigger_fired    = fire;
		res.trigger_total    = st_nxt.trigger_counter;
		res.publish          = pub;
		res.publish_value_q4 = !pub ? 14'd0 : (clr ? CLEAR_MARK_Q4 : {1'b0, dist_val});
	end

endmodule

// ===== test/tb_ultrasonic_range_median_trigger_top.sv =====
module tb_ultrasonic_range_median_trigger_top;
	import rurm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_PHASES = 12;
	localparam int POLLS_PER_PHASE = 160;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [15:0]       width_a = '0;
	logic [15:0]       width_b = '0;
	logic [15:0]       width_c = '0;
	logic              echo_ok_a = 1'b0;
	logic              echo_ok_b = 1'b0;
	logic              echo_ok_c = 1'b0;
	logic [31:0]       now_ms = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        valid_pings;
	logic [12:0]       distance_q4;
	logic              have_distance;
	logic              is_clear;
	logic              trigger_fired;
	logic [31:0]       trigger_total;
	logic              publish;
	logic [13:0]       publish_value_q4;

	cfg_t        shadow_cfg = '{pub_period: 16'd1, trigger_cm: 10'd0, clear_dist: 10'd0};
	logic        near_target = 1'b0;
	logic [31:0] last_publish = '0;
	logic [31:0] trigger_count = '0;

	res_t        expected_readings[$];
	int          mismatches = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	logic [31:0] clock_ms = '0;
	logic [8:0]  stall_phase = '0;

	ultrasonic_range_median_trigger_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.width_a(width_a),
		.width_b(width_b),
		.width_c(width_c),
		.echo_ok_a(echo_ok_a),
		.echo_ok_b(echo_ok_b),
		.echo_ok_c(echo_ok_c),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.valid_pings(valid_pings),
		.distance_q4(distance_q4),
		.have_distance(have_distance),
		.is_clear(is_clear),
		.trigger_fired(trigger_fired),
		.trigger_total(trigger_total),
		.publish(publish),
		.publish_value_q4(publish_value_q4)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic res_t predict_reading(input req_t r);
		logic [15:0] w_in[3];
		logic        ok_in[3];
		logic [31:0] v[3];
		int          n;
		logic [31:0] w;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] trig_us;
		logic [31:0] hyst;
		logic [31:0] period;
		logic        clear;
		res_t        e;
		e = '0;
		w_in[0] = r.width_a;
		w_in[1] = r.width_b;
		w_in[2] = r.width_c;
		ok_in[0] = r.echo_ok_a;
		ok_in[1] = r.echo_ok_b;
		ok_in[2] = r.echo_ok_c;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			if (ok_in[i] && w_in[i] >= MIN_ECHO_US && w_in[i] <= MAX_ECHO_US) begin
				v[n] = 32'(w_in[i]);
				n++;
			end
		end
		if (n > 0) begin
			if (n == 1) begin
				w = v[0];
			end else if (n == 2) begin
				w = (v[0] > v[1]) ? v[0] : v[1];
			end else begin
				lo = (v[0] < v[1]) ? v[0] : v[1];
				hi = (v[0] < v[1]) ? v[1] : v[0];
				w = (v[2] < lo) ? lo : ((v[2] > hi) ? hi : v[2]);
			end
			e.distance_q4 = 13'((w * 32'd16) / 32'(US_PER_CM));
			clear = (shadow_cfg.clear_dist != 0) &&
				(w >= 32'(US_PER_CM) * 32'(shadow_cfg.clear_dist));
			e.is_clear = clear;
			e.have_distance = !clear;
			if (shadow_cfg.trigger_cm != 0) begin
				trig_us = 32'(US_PER_CM) * 32'(shadow_cfg.trigger_cm);
				hyst = (trig_us < 32'(HYST_MIN_US)) ? 32'(HYST_MIN_US) : trig_us;
				if (clear || (w * 32'd10 >= trig_us * 32'd10 + hyst)) begin
					near_target = 1'b0;
				end else if (!near_target && w < trig_us) begin
					near_target = 1'b1;
					trigger_count = trigger_count + 32'd1;
					e.trigger_fired = 1'b1;
				end
			end
			period = (shadow_cfg.pub_period == 0) ? 32'd1 : 32'(shadow_cfg.pub_period);
			if (r.now_ms - last_publish >= period * 32'(MS_PER_S)) begin
				e.publish = 1'b1;
				e.publish_value_q4 = clear ? CLEAR_MARK_Q4 : 14'(e.distance_q4);
				last_publish = r.now_ms;
			end
		end
		e.valid_pings = 2'(n);
		e.trigger_total = trigger_count;
		return e;
	endfunction

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_POLL_PERIOD: shadow_cfg.pub_period = val[15:0];
			REG_TRIGGER:     shadow_cfg.trigger_cm = val[9:0];
			REG_CLEAR:       shadow_cfg.clear_dist = val[9:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_thresholds(input logic [15:0] per_sec, input logic [9:0] trig,
			input logic [9:0] clr);
		cfg_write(REG_POLL_PERIOD, 32'(per_sec));
		cfg_write(REG_TRIGGER, 32'(trig));
		cfg_write(REG_CLEAR, 32'(clr));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_poll(input logic [15:0] wa, input logic [15:0] wb,
			input logic [15:0] wc, input logic oka, input logic okb, input logic okc,
			input logic [31:0] t_ms);
		req_t r;
		r = '{width_a: wa, width_b: wb, width_c: wc, echo_ok_a: oka, echo_ok_b: okb,
			echo_ok_c: okc, now_ms: t_ms};
		if (burst_left == 0) begin
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(posedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
		in_valid <= 1'b1;
		width_a <= r.width_a;
		width_b <= r.width_b;
		width_c <= r.width_c;
		echo_ok_a <= r.echo_ok_a;
		echo_ok_b <= r.echo_ok_b;
		echo_ok_c <= r.echo_ok_c;
		now_ms <= r.now_ms;
		do @(posedge clk); while (in_stall);
		expected_readings.push_back(predict_reading(r));
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0d got %0d", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request pending", $realtime);
			end else begin
				e = expected_readings.pop_front();
				check_field("valid_pings", 32'(e.valid_pings), 32'(valid_pings));
				check_field("distance_q4", 32'(e.distance_q4), 32'(distance_q4));
				check_field("have_distance", 32'(e.have_distance), 32'(have_distance));
				check_field("is_clear", 32'(e.is_clear), 32'(is_clear));
				check_field("trigger_fired", 32'(e.trigger_fired), 32'(trigger_fired));
				check_field("trigger_total", e.trigger_total, trigger_total);
				check_field("publish", 32'(e.publish), 32'(publish));
				check_field("publish_value_q4", 32'(e.publish_value_q4),
					32'(publish_value_q4));
			end
		end
	end

	always @(posedge clk) begin
		stall_phase <= stall_phase + 9'd1;
		case (stall_phase[8:6])
			3'd2:    out_stall <= 1'($urandom_range(1, 0));
			3'd3:    out_stall <= (stall_phase[2:0] < 3'd3);
			3'd4:    out_stall <= ($urandom_range(3, 0) != 0);
			3'd5:    out_stall <= ($urandom_range(3, 0) == 0);
			3'd7:    out_stall <= stall_phase[3];
			default: out_stall <= 1'b0;
		endcase
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [15:0] rand_width();
		int c;
		int lo;
		int hi;
		int hyst;
		case ($urandom_range(9, 0))
			0: return 16'($urandom_range(65535, 0));
			1: begin
				case ($urandom_range(5, 0))
					0:       return 16'd99;
					1:       return 16'd100;
					2:       return 16'd25000;
					3:       return 16'd25001;
					4:       return 16'd0;
					default: return 16'd65535;
				endcase
			end
			2, 3, 4: begin
				c = 58 * int'(shadow_cfg.trigger_cm);
				hyst = (c < 5800) ? 5800 : c;
				lo = (c > 3000) ? c - 3000 : 0;
				hi = c + hyst / 10 + 600;
				if (hi > 65535)
					hi = 65535;
				return 16'($urandom_range(hi, lo));
			end
			5: begin
				c = 58 * int'(shadow_cfg.clear_dist);
				lo = (c > 200) ? c - 200 : 0;
				hi = (c + 200 > 65535) ? 65535 : c + 200;
				return 16'($urandom_range(hi, lo));
			end
			default: return 16'($urandom_range(25000, 100));
		endcase
	endfunction

	task automatic send_random_poll();
		int period_ms;
		period_ms = (shadow_cfg.pub_period == 0) ? 1000 : 1000 * int'(shadow_cfg.pub_period);
		case ($urandom_range(19, 0))
			0:       clock_ms = $urandom;
			1:       clock_ms = clock_ms + 32'($urandom_range(2 * period_ms, 0));
			default: clock_ms = clock_ms + 32'($urandom_range(1500, 0));
		endcase
		send_poll(rand_width(), rand_width(), rand_width(), $urandom_range(99, 0) < 85,
			$urandom_range(99, 0) < 85, $urandom_range(99, 0) < 85, clock_ms);
	endtask

	task automatic test_reset_values();
		send_poll(16'd1000, 16'd1000, 16'd1000, 1'b0, 1'b0, 1'b0, 32'd5000);
		send_poll(16'd99, 16'd100, 16'd25001, 1'b1, 1'b1, 1'b1, 32'd500);
		send_poll(16'd25000, 16'd0, 16'd65535, 1'b1, 1'b1, 1'b1, 32'd1000);
		send_poll(16'd3000, 16'd5000, 16'd9000, 1'b1, 1'b1, 1'b0, 32'd1500);
		send_poll(16'd7000, 16'd2000, 16'd4000, 1'b1, 1'b1, 1'b1, 32'd2000);
		send_poll(16'd65535, 16'd1160, 16'd0, 1'b0, 1'b1, 1'b0, 32'd3000);
	endtask

	task automatic test_trigger_hysteresis();
		wait_drained();
		set_thresholds(16'd0, 10'd50, 10'd300);
		send_poll(16'd4000, 16'd4000, 16'd4000, 1'b1, 1'b1, 1'b1, 32'd10000);
		send_poll(16'd2899, 16'd2899, 16'd2899, 1'b1, 1'b1, 1'b1, 32'd11000);
		send_poll(16'd2000, 16'd2000, 16'd2000, 1'b1, 1'b1, 1'b1, 32'd11999);
		send_poll(16'd3400, 16'd3400, 16'd3400, 1'b1, 1'b1, 1'b1, 32'd13000);
		send_poll(16'd2500, 16'd2500, 16'd2500, 1'b1, 1'b1, 1'b1, 32'd14000);
		send_poll(16'd3480, 16'd3480, 16'd3480, 1'b1, 1'b1, 1'b1, 32'd15000);
		send_poll(16'd2900, 16'd2900, 16'd2900, 1'b1, 1'b1, 1'b1, 32'd16000);
		send_poll(16'd2899, 16'd2899, 16'd2899, 1'b1, 1'b1, 1'b1, 32'd17000);
		send_poll(16'd17400, 16'd17400, 16'd17400, 1'b1, 1'b1, 1'b1, 32'd18000);
		send_poll(16'd2000, 16'd2000, 16'd2000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FF00);
		send_poll(16'd2000, 16'd2000, 16'd2000, 1'b0, 1'b0, 1'b0, 32'h0000_0400);
		send_poll(16'd17399, 16'd2000, 16'd2000, 1'b1, 1'b0, 1'b0, 32'h0000_0300);
	endtask

	task automatic test_threshold_extremes();
		wait_drained();
		set_thresholds(16'd65535, 10'd1023, 10'd1023);
		send_poll(16'd25000, 16'd24000, 16'd100, 1'b1, 1'b1, 1'b1, 32'd1000);
		send_poll(16'd100, 16'd100, 16'd100, 1'b1, 1'b1, 1'b1, 32'd65535000);
		send_poll(16'd30000, 16'd20000, 16'd0, 1'b1, 1'b1, 1'b1, 32'd65536000);
		wait_drained();
		set_thresholds(16'd1, 10'd1, 10'd1);
		send_poll(16'd100, 16'd200, 16'd300, 1'b1, 1'b1, 1'b1, 32'd70000000);
		wait_drained();
		cfg_write(REG_TRIGGER, 32'd0);
		send_poll(16'd150, 16'd150, 16'd150, 1'b1, 1'b1, 1'b1, 32'd70000999);
		send_poll(16'd25000, 16'd25000, 16'd25000, 1'b1, 1'b1, 1'b1, 32'd70001000);
	endtask

	task automatic test_random_polls();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0:       set_thresholds(16'd65535, 10'd1023, 10'd1023);
				1:       set_thresholds(16'd0, 10'd1, 10'd1);
				2:       set_thresholds(16'd1, 10'd0, 10'd0);
				3:       set_thresholds(16'd2, 10'($urandom_range(400, 20)), 10'd0);
				default: set_thresholds(16'($urandom_range(5, 0)),
					10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)));
			endcase
			gaps_on = (phase % 3 != 1);
			burst_left = 0;
			for (int k = 0; k < POLLS_PER_PHASE; k++) begin
				if ($urandom_range(99, 0) == 0)
					wait_drained();
				send_random_poll();
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_trigger_hysteresis();
		test_threshold_extremes();
		test_random_polls();
		wait_drained();
		repeat (6) @(posedge clk);
		if (expected_readings.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
